FILE: rtl/assert_macros.svh
// assertion helpers for the tokenizer checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define CHK_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

FILE: rtl/htok_pkg.sv
package htok_pkg;

    localparam logic [3:0] EV_TEXT_OPEN    = 4'd0;
    localparam logic [3:0] EV_START_OPEN   = 4'd1;
    localparam logic [3:0] EV_END_OPEN     = 4'd2;
    localparam logic [3:0] EV_COMMENT_OPEN = 4'd3;
    localparam logic [3:0] EV_DOCTYPE_OPEN = 4'd4;
    localparam logic [3:0] EV_NAME         = 4'd5;
    localparam logic [3:0] EV_ATTR_OPEN    = 4'd6;
    localparam logic [3:0] EV_ATTR_NAME    = 4'd7;
    localparam logic [3:0] EV_ATTR_VALUE   = 4'd8;
    localparam logic [3:0] EV_DATA         = 4'd9;
    localparam logic [3:0] EV_CLOSE        = 4'd10;

    typedef enum logic [16:0] {
        M_TOP            = 17'h00001,
        M_LT             = 17'h00002,
        M_BANG           = 17'h00004,
        M_COMMENT        = 17'h00008,
        M_DT_WS          = 17'h00010,
        M_DT_DATA        = 17'h00020,
        M_END_NAME       = 17'h00040,
        M_END_WS         = 17'h00080,
        M_S_NAME         = 17'h00100,
        M_S_BEFORE_ATTR  = 17'h00200,
        M_S_ATTR_NAME    = 17'h00400,
        M_S_AFTER_NAME   = 17'h00800,
        M_S_BEFORE_VALUE = 17'h01000,
        M_S_QVAL         = 17'h02000,
        M_S_UVAL         = 17'h04000,
        M_S_SLASH        = 17'h08000,
        M_XCLOSE         = 17'h10000
    } t_mode;

    typedef enum logic [1:0] {
        SRC_CUR  = 2'd0,
        SRC_HELD = 2'd1,
        SRC_REST = 2'd2
    } t_src;

    typedef struct packed {
        logic load;
        logic feed;
        logic fin;
        t_src src;
        logic rep_inc;
        logic rest_inc;
        logic hc_clr;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic ok;
        logic again;
        logic replay;
        logic rest;
        logic fin_end;
        logic rep_end;
        logic rest_end;
        logic is_fin;
        logic hold_v;
        logic adv;
    } t_stat;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_SPACE = 8'h20;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_sp(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A)
            || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_tag(input logic [7:0] c);
        return is_alnum(c) || c == CH_DASH || c == CH_UNDER || c == CH_COLON;
    endfunction

    function automatic logic is_attr(input logic [7:0] c);
        return is_tag(c) || c == CH_DOT;
    endfunction

    // "!doctype" spelled in lower case
    function automatic logic [7:0] dt_char(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = CH_BANG;
            3'd1:    r = 8'h64;
            3'd2:    r = 8'h6F;
            3'd3:    r = 8'h63;
            3'd4:    r = 8'h74;
            3'd5:    r = 8'h79;
            3'd6:    r = 8'h70;
            default: r = 8'h65;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/html_tokenizer.sv
// streaming html tokenizer
// input channel: i_in_valid/o_in_ready carry one document byte (i_in_byte) and
// i_is_final, high on the last byte of a document. output channel:
// o_out_valid/i_out_ready carry one token event per transaction
// (o_event_res, o_out_byte, o_self_closing), with o_last high on the final
// event caused by an input byte; a byte that causes no event gives none.
// one byte is worked at a time by a sequencer that runs the scan step once per
// cycle unless the output stalls, and emits at most one event per step; a byte
// is accepted, then scanned step by step, then its held event is released.
// a lookahead mismatch after "<!" replays up to seven held bytes as text
// through the scan step and then ends the replay; a final byte adds the
// closing steps of every open token.
// reset (synchronous, active low) returns the scanner to top level with no
// token open and empties the output and hold registers.
// when the receiver stalls the output register holds its event, the
// sequencer waits on the next event, and no new byte is taken until all
// events of the current byte have reached the output register.
module html_tokenizer
    import htok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_final,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_event_res,
    output logic [7:0] o_out_byte,
    output logic       o_self_closing,
    output logic       o_last
);

    t_cmd  cmd;
    t_stat stat;

    htok_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    htok_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_byte      (i_in_byte),
        .i_is_final     (i_is_final),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_event_res    (o_event_res),
        .o_out_byte     (o_out_byte),
        .o_self_closing (o_self_closing),
        .o_last         (o_last)
    );

endmodule

FILE: rtl/htok_ctrl.sv
module htok_ctrl
    import htok_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_FEED    = 7'b0000010,
        S_REP_IN  = 7'b0000100,
        S_FIN     = 7'b0001000,
        S_REP_FIN = 7'b0010000,
        S_REST    = 7'b0100000,
        S_FLUSH   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.src  = SRC_CUR;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_FEED;
                end
            end
            S_FEED: begin
                o_cmd.feed = 1'b1;
                if (i_stat.ok) begin
                    if (i_stat.replay) begin
                        n_state = S_REP_IN;
                    end else if (!i_stat.again) begin
                        n_state = i_stat.is_fin ? S_FIN : S_FLUSH;
                    end
                end
            end
            S_REP_IN, S_REP_FIN: begin
                if (i_stat.rep_end) begin
                    o_cmd.hc_clr = 1'b1;
                    n_state = (r_state == S_REP_IN) ? S_FEED : S_FIN;
                end else begin
                    o_cmd.feed = 1'b1;
                    o_cmd.src  = SRC_HELD;
                    if (i_stat.ok && !i_stat.again) o_cmd.rep_inc = 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                if (i_stat.ok) begin
                    if (i_stat.fin_end) n_state = S_FLUSH;
                    else if (i_stat.replay) n_state = S_REP_FIN;
                    else if (i_stat.rest) n_state = S_REST;
                end
            end
            S_REST: begin
                if (i_stat.rest_end) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.feed = 1'b1;
                    o_cmd.src  = SRC_REST;
                    if (i_stat.ok && i_stat.replay) n_state = S_REP_FIN;
                    else if (i_stat.ok && !i_stat.again) o_cmd.rest_inc = 1'b1;
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                if (!i_stat.hold_v || i_stat.adv) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: rtl/htok_dp.sv
module htok_dp
    import htok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_final,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output logic [3:0] o_event_res,
    output logic [7:0] o_out_byte,
    output logic       o_self_closing,
    output logic       o_last
);

    t_mode      r_mode, n_mode;
    logic [7:0] r_held [8];
    logic [7:0] n_held [8];
    logic [3:0] r_hc, n_hc;
    logic [7:0] r_quote, n_quote;
    logic       r_pend, n_pend;
    logic       r_topen, n_topen;
    logic [7:0] r_cur;
    logic       r_fin;
    logic [2:0] r_rep;
    logic [7:0] r_rest [2];
    logic [7:0] n_rest [2];
    logic [1:0] r_rest_n, n_rest_n;
    logic [1:0] r_ri;

    // one-deep hold so the final event of a byte can carry last
    logic       r_h_valid;
    logic [3:0] r_h_ev;
    logic [7:0] r_h_byte;
    logic       r_h_sc;

    logic       r_o_valid;
    logic [3:0] r_o_ev;
    logic [7:0] r_o_byte;
    logic       r_o_sc;
    logic       r_o_last;

    logic       e_v;
    logic [3:0] e_ev;
    logic [7:0] e_byte;
    logic       e_sc;
    logic       again, replay, rest, fin_end, set_rep;

    logic [7:0] c, lc;
    logic [2:0] hn;
    logic       cm_pre, dt_pre;
    logic       adv, ok, exec, push_hold, flush_go;

    assign adv = !r_o_valid || i_out_ready;

    always_comb begin
        case (i_cmd.src)
            SRC_HELD: c = r_held[r_rep];
            SRC_REST: c = r_rest[r_ri[0]];
            default:  c = r_cur;
        endcase
    end

    assign lc = to_lower(c);
    assign hn = r_hc[2:0];
    // held bytes always spell a prefix of one of the two patterns
    assign cm_pre = (hn <= 3'd1) || (r_held[1] == CH_DASH);
    assign dt_pre = (hn <= 3'd1) || (to_lower(r_held[1]) == dt_char(3'd1));

    always_comb begin
        n_mode   = r_mode;
        n_held   = r_held;
        n_hc     = r_hc;
        n_quote  = r_quote;
        n_pend   = r_pend;
        n_topen  = r_topen;
        n_rest   = r_rest;
        n_rest_n = r_rest_n;
        e_v      = 1'b0;
        e_ev     = EV_CLOSE;
        e_byte   = 8'd0;
        e_sc     = 1'b0;
        again    = 1'b0;
        replay   = 1'b0;
        rest     = 1'b0;
        fin_end  = 1'b0;
        set_rep  = 1'b0;
        if (i_cmd.fin) begin
            unique case (r_mode)
                M_TOP: begin
                    e_v     = r_topen;
                    n_topen = 1'b0;
                    n_pend  = 1'b0;
                    fin_end = 1'b1;
                end
                M_LT, M_BANG: begin
                    e_v    = 1'b1;
                    e_ev   = EV_START_OPEN;
                    n_mode = M_XCLOSE;
                end
                M_XCLOSE: begin
                    e_v     = 1'b1;
                    n_mode  = M_TOP;
                    replay  = 1'b1;
                    set_rep = 1'b1;
                end
                M_COMMENT: begin
                    e_v       = 1'b1;
                    n_mode    = M_TOP;
                    n_rest[0] = r_held[0];
                    n_rest[1] = r_held[1];
                    n_rest_n  = (r_hc > 4'd2) ? 2'd2 : r_hc[1:0];
                    n_hc      = 4'd0;
                    rest      = 1'b1;
                end
                default: begin
                    e_v    = 1'b1;
                    e_sc   = (r_mode == M_S_SLASH);
                    n_mode = M_TOP;
                end
            endcase
        end else begin
            unique case (r_mode)
                M_TOP: begin
                    if (c == CH_LT) begin
                        e_v     = r_topen;
                        n_topen = 1'b0;
                        n_pend  = 1'b0;
                        n_mode  = M_LT;
                    end else if (is_sp(c)) begin
                        if (r_topen) n_pend = 1'b1;
                    end else if (!r_topen) begin
                        e_v     = 1'b1;
                        e_ev    = EV_TEXT_OPEN;
                        n_topen = 1'b1;
                        n_pend  = 1'b0;
                        again   = 1'b1;
                    end else if (r_pend) begin
                        e_v    = 1'b1;
                        e_ev   = EV_DATA;
                        e_byte = CH_SPACE;
                        n_pend = 1'b0;
                        again  = 1'b1;
                    end else begin
                        e_v    = 1'b1;
                        e_ev   = EV_DATA;
                        e_byte = c;
                    end
                end
                M_LT: begin
                    if (c == CH_SLASH) begin
                        e_v    = 1'b1;
                        e_ev   = EV_END_OPEN;
                        n_mode = M_END_NAME;
                    end else if (c == CH_BANG) begin
                        n_held[0] = c;
                        n_hc      = 4'd1;
                        n_mode    = M_BANG;
                    end else begin
                        e_v    = 1'b1;
                        e_ev   = EV_START_OPEN;
                        n_mode = M_S_NAME;
                        again  = 1'b1;
                    end
                end
                M_BANG: begin
                    if (hn < 3'd3 && cm_pre && lc == CH_DASH && hn != 3'd0) begin
                        if (hn == 3'd2) begin
                            e_v    = 1'b1;
                            e_ev   = EV_COMMENT_OPEN;
                            n_hc   = 4'd0;
                            n_mode = M_COMMENT;
                        end else begin
                            n_held[hn] = c;
                            n_hc       = {1'b0, hn} + 4'd1;
                        end
                    end else if (dt_pre && lc == dt_char(hn)) begin
                        if (hn == 3'd7) begin
                            e_v    = 1'b1;
                            e_ev   = EV_DOCTYPE_OPEN;
                            n_hc   = 4'd0;
                            n_mode = M_DT_WS;
                        end else begin
                            n_held[hn] = c;
                            n_hc       = {1'b0, hn} + 4'd1;
                        end
                    end else begin
                        e_v    = 1'b1;
                        e_ev   = EV_START_OPEN;
                        n_mode = M_XCLOSE;
                        again  = 1'b1;
                    end
                end
                M_XCLOSE: begin
                    e_v     = 1'b1;
                    n_mode  = M_TOP;
                    replay  = 1'b1;
                    set_rep = 1'b1;
                end
                M_COMMENT: begin
                    if (r_hc >= 4'd2) begin
                        if (r_held[0] == CH_DASH && r_held[1] == CH_DASH && c == CH_GT) begin
                            e_v    = 1'b1;
                            n_hc   = 4'd0;
                            n_mode = M_TOP;
                        end else begin
                            e_v       = 1'b1;
                            e_ev      = EV_DATA;
                            e_byte    = r_held[0];
                            n_held[0] = r_held[1];
                            n_held[1] = c;
                            n_hc      = 4'd2;
                        end
                    end else begin
                        n_held[{2'b00, r_hc[0]}] = c;
                        n_hc = r_hc + 4'd1;
                    end
                end
                M_DT_WS, M_DT_DATA: begin
                    if (c == CH_GT) begin
                        e_v    = 1'b1;
                        n_mode = M_TOP;
                    end else if (!(r_mode == M_DT_WS && is_sp(c))) begin
                        e_v    = 1'b1;
                        e_ev   = EV_DATA;
                        e_byte = c;
                        n_mode = M_DT_DATA;
                    end
                end
                M_END_NAME, M_END_WS: begin
                    if (r_mode == M_END_NAME && is_tag(c)) begin
                        e_v    = 1'b1;
                        e_ev   = EV_NAME;
                        e_byte = lc;
                    end else if (is_sp(c)) begin
                        n_mode = M_END_WS;
                    end else begin
                        e_v    = 1'b1;
                        n_mode = M_TOP;
                        again  = (c != CH_GT);
                    end
                end
                M_S_NAME: begin
                    if (is_tag(c)) begin
                        e_v    = 1'b1;
                        e_ev   = EV_NAME;
                        e_byte = lc;
                    end else begin
                        n_mode = M_S_BEFORE_ATTR;
                        again  = 1'b1;
                    end
                end
                M_S_BEFORE_ATTR: begin
                    if (is_sp(c)) begin
                        n_mode = r_mode;
                    end else if (c == CH_GT) begin
                        e_v    = 1'b1;
                        n_mode = M_TOP;
                    end else if (c == CH_SLASH) begin
                        n_mode = M_S_SLASH;
                    end else if (is_attr(c)) begin
                        // name byte follows on the next pass
                        e_v    = 1'b1;
                        e_ev   = EV_ATTR_OPEN;
                        n_mode = M_S_ATTR_NAME;
                        again  = 1'b1;
                    end else begin
                        e_v    = 1'b1;
                        n_mode = M_TOP;
                        again  = 1'b1;
                    end
                end
                M_S_ATTR_NAME: begin
                    if (is_attr(c)) begin
                        e_v    = 1'b1;
                        e_ev   = EV_ATTR_NAME;
                        e_byte = lc;
                    end else begin
                        n_mode = M_S_AFTER_NAME;
                        again  = 1'b1;
                    end
                end
                M_S_AFTER_NAME: begin
                    if (c == CH_EQ) begin
                        n_mode = M_S_BEFORE_VALUE;
                    end else if (!is_sp(c)) begin
                        n_mode = M_S_BEFORE_ATTR;
                        again  = 1'b1;
                    end
                end
                M_S_BEFORE_VALUE: begin
                    if (c == CH_DQ || c == CH_SQ) begin
                        n_quote = c;
                        n_mode  = M_S_QVAL;
                    end else if (!is_sp(c)) begin
                        n_mode = M_S_UVAL;
                        again  = 1'b1;
                    end
                end
                M_S_QVAL: begin
                    if (c == r_quote) begin
                        n_mode = M_S_BEFORE_ATTR;
                    end else begin
                        e_v    = 1'b1;
                        e_ev   = EV_ATTR_VALUE;
                        e_byte = c;
                    end
                end
                M_S_UVAL: begin
                    if (is_sp(c) || c == CH_GT || c == CH_SLASH) begin
                        n_mode = M_S_BEFORE_ATTR;
                        again  = 1'b1;
                    end else begin
                        e_v    = 1'b1;
                        e_ev   = EV_ATTR_VALUE;
                        e_byte = c;
                    end
                end
                M_S_SLASH: begin
                    e_v    = 1'b1;
                    e_sc   = 1'b1;
                    n_mode = M_TOP;
                    again  = (c != CH_GT);
                end
                default: begin
                    n_mode = M_TOP;
                    again  = 1'b1;
                end
            endcase
        end
    end

    assign ok        = !e_v || !r_h_valid || adv;
    assign exec      = (i_cmd.feed || i_cmd.fin) && ok;
    assign push_hold = exec && e_v && r_h_valid;
    assign flush_go  = i_cmd.flush && r_h_valid && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_TOP;
            r_hc      <= 4'd0;
            r_quote   <= 8'd0;
            r_pend    <= 1'b0;
            r_topen   <= 1'b0;
            r_rep     <= 3'd0;
            r_ri      <= 2'd0;
            r_rest_n  <= 2'd0;
            r_h_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (exec) begin
                r_mode   <= n_mode;
                r_quote  <= n_quote;
                r_pend   <= n_pend;
                r_topen  <= n_topen;
                r_rest_n <= n_rest_n;
                r_hc     <= n_hc;
            end else if (i_cmd.hc_clr) begin
                r_hc <= 4'd0;
            end
            if (exec && set_rep) r_rep <= 3'd0;
            else if (i_cmd.rep_inc) r_rep <= r_rep + 3'd1;
            if (exec && rest) r_ri <= 2'd0;
            else if (i_cmd.rest_inc) r_ri <= r_ri + 2'd1;
            if (exec && e_v) r_h_valid <= 1'b1;
            else if (flush_go) r_h_valid <= 1'b0;
            if (push_hold || flush_go) r_o_valid <= 1'b1;
            else if (i_out_ready) r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur <= i_in_byte;
            r_fin <= i_is_final;
        end
        if (exec) begin
            r_held <= n_held;
            r_rest <= n_rest;
        end
        if (exec && e_v) begin
            r_h_ev   <= e_ev;
            r_h_byte <= e_byte;
            r_h_sc   <= e_sc;
        end
        if (push_hold || flush_go) begin
            r_o_ev   <= r_h_ev;
            r_o_byte <= r_h_byte;
            r_o_sc   <= r_h_sc;
            r_o_last <= flush_go;
        end
    end

    always_comb begin
        o_stat          = '0;
        o_stat.ok       = ok;
        o_stat.again    = again;
        o_stat.replay   = replay;
        o_stat.rest     = rest;
        o_stat.fin_end  = fin_end;
        o_stat.rep_end  = (r_rep == hn);
        o_stat.rest_end = (r_ri == r_rest_n);
        o_stat.is_fin   = r_fin;
        o_stat.hold_v   = r_h_valid;
        o_stat.adv      = adv;
    end

    assign o_out_valid    = r_o_valid;
    assign o_event_res    = r_o_ev;
    assign o_out_byte     = r_o_byte;
    assign o_self_closing = r_o_sc;
    assign o_last         = r_o_last;

endmodule

FILE: rtl/htok_chk.sv
`include "assert_macros.svh"

module htok_chk
    import htok_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [3:0] o_event_res,
    input logic [7:0] o_out_byte,
    input logic       o_self_closing,
    input logic       o_last
);

    // one byte at a time: no back to back input transactions
    `CHK_NEXT(a_in_busy, i_in_valid && o_in_ready, !o_in_ready)

    // a stalled event stays put
    `CHK_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_event_res) && $stable(o_out_byte) && $stable(o_last))

    `CHK_IMPLY(a_ev_range, o_out_valid, o_event_res <= EV_CLOSE)

    // only byte-carrying events have a nonzero byte
    `CHK_IMPLY(a_byte_zero, o_out_valid && o_event_res != EV_NAME && o_event_res != EV_ATTR_NAME && o_event_res != EV_ATTR_VALUE && o_event_res != EV_DATA, o_out_byte == 8'd0)

    `CHK_IMPLY(a_sc_close, o_out_valid && o_self_closing, o_event_res == EV_CLOSE)

endmodule

bind html_tokenizer htok_chk u_chk (.*);
